### src/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// shared constants and types for the binary32 adder
// ----------------------------------------------------------------------------
package fpa_pkg;
   localparam int unsigned WordWidth = 32;
   localparam logic [31:0] CanonNan  = 32'h7fffffff;
   localparam logic [7:0]  ExpMax    = 8'd255;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type operand_a;
      word_type operand_b;
   } req_payload_type;

   typedef struct packed {
      word_type sum_bits;
   } rsp_payload_type;
endpackage

### src/fpa_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface fpa_stream_if #(
   parameter type payload_type = logic [31:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/fp32_adder.sv
`timescale 1ns / 1ps
// a request transaction goes into the input register, through the single
// combinational add path and into the result register, which drives response
// valid; throughput: one transaction per cycle while rsp.ready does not stall.
// reset clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// fp32_adder
// binary32 adder, round to nearest even, with denormals and canonical nan
// ----------------------------------------------------------------------------
module fp32_adder
   import fpa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fpa_stream_if.sink   req,
   fpa_stream_if.source rsp
);
   logic            in_vld_ff, out_vld_ff;
   req_payload_type in_data_ff;
   word_type        out_data_ff, result;
   logic            adv_out, adv_in;

   // pipeline flow control
   assign adv_out   = !out_vld_ff || rsp.ready;
   assign adv_in    = !in_vld_ff || adv_out;
   assign req.ready = adv_in;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload.sum_bits = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv_in) in_vld_ff <= req.valid;
         if (adv_out) out_vld_ff <= in_vld_ff;
      end
      if (adv_in && req.valid) in_data_ff <= req.payload;
      if (adv_out && in_vld_ff) out_data_ff <= result;
   end

   // add datapath
   logic [31:0] a, b, big, sml;
   logic [7:0]  ea, eb, eb_g, es_g;
   logic        a_nan, b_nan, a_inf, b_inf, sgn, sub;
   logic [26:0] mb, ms, ms_sh;
   logic [7:0]  d;
   logic [27:0] sum;
   logic [26:0] nrm;
   logic [4:0]  lz;
   logic [8:0]  e;
   logic [24:0] mant;
   logic [2:0]  g;
   logic [53:0] wide;

   always_comb begin
      a = in_data_ff.operand_a;
      b = in_data_ff.operand_b;
      ea = a[30:23];
      eb = b[30:23];
      a_nan = (ea == ExpMax) && (a[22:0] != '0);
      b_nan = (eb == ExpMax) && (b[22:0] != '0);
      a_inf = (ea == ExpMax) && !a_nan;
      b_inf = (eb == ExpMax) && !b_nan;
      if (a[30:0] >= b[30:0]) begin
         big = a; sml = b;
      end else begin
         big = b; sml = a;
      end
      sgn  = big[31];
      sub  = a[31] ^ b[31];
      eb_g = (big[30:23] == '0) ? 8'd1 : big[30:23];
      es_g = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
      mb = {(big[30:23] != '0), big[22:0], 3'b000};
      ms = {(sml[30:23] != '0), sml[22:0], 3'b000};
      d  = eb_g - es_g;
      // alignment with sticky
      wide  = {ms, 27'd0} >> ((d >= 8'd27) ? 8'd27 : d);
      ms_sh = wide[53:27] | {26'd0, (wide[26:0] != '0)};
      sum = sub ? ({1'b0, mb} - {1'b0, ms_sh}) : ({1'b0, mb} + {1'b0, ms_sh});
      // leading zero count on bits 26..0
      lz = 5'd27;
      for (int i = 0; i <= 26; i++) if (sum[i]) lz = 5'(26 - i);
      e = {1'b0, eb_g};
      if (sum[27]) begin
         nrm = sum[27:1] | {26'd0, sum[0]};
         e   = e + 9'd1;
      end else if ({4'd0, lz} < e - 9'd1) begin
         nrm = sum[26:0] << lz;
         e   = e - {4'd0, lz};
      end else begin
         nrm = sum[26:0] << (e - 9'd1);
         e   = 9'd1;
      end
      // round to nearest even
      g    = nrm[2:0];
      mant = {1'b0, nrm[26:3]};
      if (g > 3'd4 || (g == 3'd4 && mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
         mant = mant >> 1;
         e    = e + 9'd1;
      end
      if (e >= {1'b0, ExpMax}) result = {sgn, ExpMax, 23'd0};
      else result = {sgn, (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
      if (sum == '0) result = '0;
      // special operands
      if (a[30:0] == '0 && b[30:0] == '0) result = {a[31] & b[31], 31'd0};
      else if (b[30:0] == '0) result = a;
      else if (a[30:0] == '0) result = b;
      if (a_inf && b_inf) result = sub ? CanonNan : a;
      else if (a_inf) result = a;
      else if (b_inf) result = b;
      if (a_nan || b_nan) result = CanonNan;
   end
endmodule
